/* rtl/core/spifas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spifas_pkg
// Shared types and command codes for the SPI FRAM access sequencer.
// ----------------------------------------------------------------------------
package spifas_pkg;

    // serial memory opcodes
    localparam logic [7:0] CMD_WRITE_ENABLE  = 8'h06;
    localparam logic [7:0] CMD_WRITE_DISABLE = 8'h04;
    localparam logic [7:0] CMD_READ          = 8'h03;
    localparam logic [7:0] CMD_WRITE         = 8'h02;

    // request codes on the mode field
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic        byte_mode;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        miso;
    } spifas_in_t;

    typedef struct packed {
        logic        chip_select;
        logic        sclk;
        logic        mosi;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        write_skipped;
    } spifas_out_t;

    // which frame is on the bus and which byte of it is due
    typedef struct packed {
        logic       wren;
        logic       wrdi;
        logic       rd;
        logic [2:0] idx;
        logic       byte_mode;
    } spifas_frame_sel_t;

endpackage

/* rtl/core/spifas_frame_byte.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spifas_frame_byte
// Selects the byte to transmit for a given frame and byte position.
// ----------------------------------------------------------------------------
module spifas_frame_byte (
    input  spifas_pkg::spifas_frame_sel_t sel,
    input  logic [15:0]                   address,
    input  logic [15:0]                   data,
    output logic [7:0]                    tx_byte
);
    import spifas_pkg::*;

    always_comb begin
        if (sel.wren) begin
            tx_byte = CMD_WRITE_ENABLE;
        end else if (sel.wrdi) begin
            tx_byte = CMD_WRITE_DISABLE;
        end else begin
            case (sel.idx)
                3'd0:    tx_byte = sel.rd ? CMD_READ : CMD_WRITE;
                3'd1:    tx_byte = address[15:8];
                3'd2:    tx_byte = address[7:0];
                3'd3:    tx_byte = sel.byte_mode ? data[7:0] : data[15:8];
                default: tx_byte = data[7:0];
            endcase
        end
    end

endmodule

/* rtl/core/spi_fram_access_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_fram_access_sequencer
// SPI mode-0 master serving read and compare-before-write requests to a FRAM.
// ----------------------------------------------------------------------------
// Each input transaction is one serial clock phase (tick) and yields exactly
// one result transaction carrying the bus levels and status for that tick.
// The sequencer takes one transaction per clock cycle; its state and the
// result register update together, so throughput is set only by m_ready.
// A read covers the accept tick, the READ command and two address bytes, the
// data bytes received and a gap tick; a write that is not skipped adds the
// WREN, WRITE and WRDI frames, each followed by a tick with chip select low.
// The mode field is looked at only while the sequencer is idle.
// ----------------------------------------------------------------------------
module spi_fram_access_sequencer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  spifas_pkg::spifas_in_t   s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output spifas_pkg::spifas_out_t  m_data
);
    import spifas_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_RD_SEND   = 4'd1,
        ST_RD_RECV   = 4'd2,
        ST_RD_GAP    = 4'd3,
        ST_WREN_SEND = 4'd4,
        ST_WREN_GAP  = 4'd5,
        ST_WR_SEND   = 4'd6,
        ST_WR_GAP    = 4'd7,
        ST_WRDI_SEND = 4'd8,
        ST_WRDI_GAP  = 4'd9
    } step_t;

    step_t       step_reg, step_next;
    logic        phase_reg, phase_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] data_reg, data_next;
    logic        byte_mode_reg, byte_mode_next;
    logic        is_write_reg, is_write_next;
    logic [15:0] capt_reg, capt_next;
    logic        m_valid_reg;
    spifas_out_t m_data_reg, res;

    spifas_frame_sel_t frame_sel;
    logic [7:0]        tx_byte;
    logic [2:0]        frame_len;
    logic [2:0]        bit_inc;
    logic [2:0]        byte_inc;
    logic [7:0]        tx_shift;
    logic              accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign frame_sel.wren      = (step_reg == ST_WREN_SEND);
    assign frame_sel.wrdi      = (step_reg == ST_WRDI_SEND);
    assign frame_sel.rd        = (step_reg == ST_RD_SEND);
    assign frame_sel.idx       = byte_cnt_reg;
    assign frame_sel.byte_mode = byte_mode_reg;

    spifas_frame_byte u_frame_byte (
        .sel     (frame_sel),
        .address (addr_reg),
        .data    (data_reg),
        .tx_byte (tx_byte)
    );

    assign bit_inc  = bit_cnt_reg + 3'd1;
    assign byte_inc = byte_cnt_reg + 3'd1;
    assign tx_shift = (bit_cnt_reg == 3'd0) ? tx_byte : shift_reg;

    always_comb begin
        unique case (step_reg)
            ST_RD_SEND: frame_len = 3'd3;
            ST_WR_SEND: frame_len = byte_mode_reg ? 3'd4 : 3'd5;
            default:    frame_len = 3'd1;
        endcase
    end

    always_comb begin
        step_next      = step_reg;
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        byte_mode_next = byte_mode_reg;
        is_write_next  = is_write_reg;
        capt_next      = capt_reg;
        res            = '0;

        unique case (step_reg)
            ST_IDLE: begin
                if (s_data.mode == MODE_READ || s_data.mode == MODE_WRITE) begin
                    byte_mode_next = s_data.byte_mode;
                    addr_next      = s_data.byte_mode ? s_data.address
                                                      : {s_data.address[14:0], 1'b0};
                    data_next      = s_data.write_data;
                    is_write_next  = (s_data.mode == MODE_WRITE);
                    capt_next      = '0;
                    shift_next     = '0;
                    phase_next     = 1'b0;
                    bit_cnt_next   = '0;
                    byte_cnt_next  = '0;
                    step_next      = ST_RD_SEND;
                    res.busy_res   = 1'b1;
                end
            end
            ST_RD_SEND, ST_WREN_SEND, ST_WR_SEND, ST_WRDI_SEND: begin
                res.busy_res    = 1'b1;
                res.chip_select = 1'b1;
                if (!phase_reg) begin
                    shift_next = tx_shift;
                    res.mosi   = tx_shift[7];
                    phase_next = 1'b1;
                end else begin
                    res.mosi     = shift_reg[7];
                    res.sclk     = 1'b1;
                    shift_next   = {shift_reg[6:0], 1'b0};
                    phase_next   = 1'b0;
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 3'd0) begin
                        byte_cnt_next = byte_inc;
                        if (byte_inc >= frame_len) begin
                            byte_cnt_next = '0;
                            unique case (step_reg)
                                ST_RD_SEND:   step_next = ST_RD_RECV;
                                ST_WREN_SEND: step_next = ST_WREN_GAP;
                                ST_WR_SEND:   step_next = ST_WR_GAP;
                                default:      step_next = ST_WRDI_GAP;
                            endcase
                        end
                    end
                end
            end
            ST_RD_RECV: begin
                res.busy_res    = 1'b1;
                res.chip_select = 1'b1;
                if (!phase_reg) begin
                    // sample on the low phase
                    shift_next = {shift_reg[6:0], s_data.miso};
                    phase_next = 1'b1;
                end else begin
                    res.sclk     = 1'b1;
                    phase_next   = 1'b0;
                    bit_cnt_next = bit_inc;
                    if (bit_inc == 3'd0) begin
                        capt_next     = {capt_reg[7:0], shift_reg};
                        byte_cnt_next = byte_inc;
                        if (byte_inc >= (byte_mode_reg ? 3'd1 : 3'd2)) begin
                            byte_cnt_next = '0;
                            step_next     = ST_RD_GAP;
                        end
                    end
                end
            end
            ST_RD_GAP: begin
                if (!is_write_reg) begin
                    res.done_res  = 1'b1;
                    res.read_data = capt_reg;
                    step_next     = ST_IDLE;
                end else if (capt_reg == data_reg) begin
                    // value already there, no write needed
                    res.done_res      = 1'b1;
                    res.write_skipped = 1'b1;
                    step_next         = ST_IDLE;
                end else begin
                    res.busy_res = 1'b1;
                    step_next    = ST_WREN_SEND;
                end
            end
            ST_WREN_GAP: begin
                res.busy_res = 1'b1;
                step_next    = ST_WR_SEND;
            end
            ST_WR_GAP: begin
                res.busy_res = 1'b1;
                step_next    = ST_WRDI_SEND;
            end
            ST_WRDI_GAP: begin
                res.done_res = 1'b1;
                step_next    = ST_IDLE;
            end
            default: begin
                step_next     = ST_IDLE;
                phase_next    = 1'b0;
                bit_cnt_next  = '0;
                byte_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_IDLE;
            phase_reg     <= 1'b0;
            bit_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
            shift_reg     <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            byte_mode_reg <= 1'b0;
            is_write_reg  <= 1'b0;
            capt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                step_reg      <= step_next;
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                shift_reg     <= shift_next;
                addr_reg      <= addr_next;
                data_reg      <= data_next;
                byte_mode_reg <= byte_mode_next;
                is_write_reg  <= is_write_next;
                capt_reg      <= capt_next;
                m_data_reg    <= res;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/spifas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spifas_checker
// Port-level checks on the result stream of the FRAM access sequencer.
// ----------------------------------------------------------------------------
module spifas_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input spifas_pkg::spifas_out_t m_data
);
    import spifas_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res))
        else $error("done and busy together");

    a_sclk_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.sclk || m_data.mosi) |-> m_data.chip_select && m_data.busy_res)
        else $error("bus activity outside a frame");

    a_skip_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_skipped |-> m_data.done_res && m_data.read_data == 16'd0)
        else $error("write skip flag without completion");

    a_data_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_data != 16'd0 |-> m_data.done_res && !m_data.chip_select)
        else $error("read data outside the done tick");

endmodule

bind spi_fram_access_sequencer spifas_checker u_spifas_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* test/spi_fram_access_sequencer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_fram_access_sequencer_test
// Self-checking bench for the SPI FRAM access sequencer. Each input
// transaction is one serial clock phase. A cycle-level copy of the sequencer
// predicts the bus levels and status of every tick. A simple FRAM stand-in
// drives miso while a byte is received. Both channels idle and stall at
// random. Directed reads, compare-before-write cases and idle ticks come
// first, then randomised requests with noise on the ignored fields.
// ----------------------------------------------------------------------------
module spi_fram_access_sequencer_test;
    import spifas_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // random requests run until the whole test has sent about this many ticks
    localparam int TICK_BUDGET = 1100;

    typedef enum logic [3:0] {
        STEP_IDLE, STEP_RD_SEND, STEP_RD_RECV, STEP_RD_GAP, STEP_WREN_SEND,
        STEP_WREN_GAP, STEP_WR_SEND, STEP_WR_GAP, STEP_WRDI_SEND, STEP_WRDI_GAP
    } seq_step_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    spifas_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    spifas_out_t m_data;

    spi_fram_access_sequencer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // predicted sequencer state
    seq_step_t   seq_step   = STEP_IDLE;
    logic        phase      = 1'b0;
    logic [2:0]  bit_cnt    = '0;
    logic [2:0]  byte_cnt   = '0;
    logic [7:0]  shreg      = '0;
    logic [15:0] held_addr  = '0;
    logic [15:0] held_wdata = '0;
    logic        held_bmode = 1'b0;
    logic        held_write = 1'b0;
    logic [15:0] captured   = '0;

    spifas_out_t due_bus_states[$];
    int          error_count = 0;
    int          ticks_sent  = 0;
    int          stall_left  = 0;
    bit          sender_gaps = 1'b0;
    bit          receiver_stalls = 1'b0;

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s: got %h, expected %h", name, got, want));
        end
    endtask

    // mostly short, now and then long
    function automatic int idle_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advances the predicted sequencer by one tick and returns its bus levels
    function automatic spifas_out_t predict_bus_tick(input spifas_in_t t);
        spifas_out_t r;
        logic [2:0]  frame_len;
        r = '0;
        case (seq_step)
            STEP_IDLE: begin
                if (t.mode == MODE_READ || t.mode == MODE_WRITE) begin
                    held_bmode = t.byte_mode;
                    held_addr  = t.byte_mode ? t.address : {t.address[14:0], 1'b0};
                    held_wdata = t.write_data;
                    held_write = (t.mode == MODE_WRITE);
                    captured   = '0;
                    shreg      = '0;
                    phase      = 1'b0;
                    bit_cnt    = '0;
                    byte_cnt   = '0;
                    seq_step   = STEP_RD_SEND;
                    r.busy_res = 1'b1;
                end
            end
            STEP_RD_SEND, STEP_WREN_SEND, STEP_WR_SEND, STEP_WRDI_SEND: begin
                r.busy_res    = 1'b1;
                r.chip_select = 1'b1;
                if (!phase) begin
                    if (bit_cnt == 3'd0) begin
                        case (seq_step)
                            STEP_WREN_SEND: shreg = CMD_WRITE_ENABLE;
                            STEP_WRDI_SEND: shreg = CMD_WRITE_DISABLE;
                            default: begin
                                case (byte_cnt)
                                    3'd0: shreg = (seq_step == STEP_RD_SEND) ? CMD_READ
                                                                              : CMD_WRITE;
                                    3'd1: shreg = held_addr[15:8];
                                    3'd2: shreg = held_addr[7:0];
                                    3'd3: shreg = held_bmode ? held_wdata[7:0]
                                                             : held_wdata[15:8];
                                    default: shreg = held_wdata[7:0];
                                endcase
                            end
                        endcase
                    end
                    r.mosi = shreg[7];
                    phase  = 1'b1;
                end else begin
                    r.mosi  = shreg[7];
                    r.sclk  = 1'b1;
                    shreg   = {shreg[6:0], 1'b0};
                    phase   = 1'b0;
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0) begin
                        byte_cnt = byte_cnt + 3'd1;
                        case (seq_step)
                            STEP_RD_SEND: frame_len = 3'd3;
                            STEP_WR_SEND: frame_len = held_bmode ? 3'd4 : 3'd5;
                            default:      frame_len = 3'd1;
                        endcase
                        if (byte_cnt >= frame_len) begin
                            byte_cnt = '0;
                            case (seq_step)
                                STEP_RD_SEND:   seq_step = STEP_RD_RECV;
                                STEP_WREN_SEND: seq_step = STEP_WREN_GAP;
                                STEP_WR_SEND:   seq_step = STEP_WR_GAP;
                                default:        seq_step = STEP_WRDI_GAP;
                            endcase
                        end
                    end
                end
            end
            STEP_RD_RECV: begin
                r.busy_res    = 1'b1;
                r.chip_select = 1'b1;
                if (!phase) begin
                    shreg = {shreg[6:0], t.miso};
                    phase = 1'b1;
                end else begin
                    r.sclk  = 1'b1;
                    phase   = 1'b0;
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0) begin
                        captured = {captured[7:0], shreg};
                        byte_cnt = byte_cnt + 3'd1;
                        if (byte_cnt >= (held_bmode ? 3'd1 : 3'd2)) begin
                            byte_cnt = '0;
                            seq_step = STEP_RD_GAP;
                        end
                    end
                end
            end
            STEP_RD_GAP: begin
                if (!held_write) begin
                    r.done_res  = 1'b1;
                    r.read_data = captured;
                    seq_step    = STEP_IDLE;
                end else if (captured == held_wdata) begin
                    // location already holds the value, no write cycle
                    r.done_res      = 1'b1;
                    r.write_skipped = 1'b1;
                    seq_step        = STEP_IDLE;
                end else begin
                    r.busy_res = 1'b1;
                    seq_step   = STEP_WREN_SEND;
                end
            end
            STEP_WREN_GAP: begin
                r.busy_res = 1'b1;
                seq_step   = STEP_WR_SEND;
            end
            STEP_WR_GAP: begin
                r.busy_res = 1'b1;
                seq_step   = STEP_WRDI_SEND;
            end
            STEP_WRDI_GAP: begin
                r.done_res = 1'b1;
                seq_step   = STEP_IDLE;
            end
            default: begin
                seq_step = STEP_IDLE;
                phase    = 1'b0;
                bit_cnt  = '0;
                byte_cnt = '0;
            end
        endcase
        return r;
    endfunction

    task automatic send_tick(input spifas_in_t item);
        int gap;
        gap = idle_len(sender_gaps);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_bus_states.push_back(predict_bus_tick(item));
        ticks_sent++;
    endtask

    // one request from its accepting tick to its done tick; the memory
    // stand-in holds 'stored' and answers with it while bytes are received
    task automatic run_request(input logic [1:0] req_mode, input logic bmode,
                               input logic [15:0] addr, input logic [15:0] wdata,
                               input logic [15:0] stored);
        spifas_in_t item;
        logic [3:0] pos;
        item.mode       = req_mode;
        item.byte_mode  = bmode;
        item.address    = addr;
        item.write_data = wdata;
        item.miso       = 1'($urandom_range(0, 1));
        send_tick(item);
        while (seq_step != STEP_IDLE) begin
            // request fields are ignored while busy, so fill them with noise
            item.mode       = 2'($urandom_range(0, 3));
            item.byte_mode  = 1'($urandom_range(0, 1));
            item.address    = 16'($urandom_range(0, 16'hFFFF));
            item.write_data = 16'($urandom_range(0, 16'hFFFF));
            item.miso       = 1'($urandom_range(0, 1));
            if (seq_step == STEP_RD_RECV && !phase) begin
                pos       = 4'((held_bmode ? 7 : 15) - (8 * byte_cnt + bit_cnt));
                item.miso = stored[pos];
            end
            send_tick(item);
        end
    endtask

    task automatic send_idle_tick(input logic [1:0] idle_mode);
        spifas_in_t item;
        item.mode       = idle_mode;
        item.byte_mode  = 1'($urandom_range(0, 1));
        item.address    = 16'($urandom_range(0, 16'hFFFF));
        item.write_data = 16'($urandom_range(0, 16'hFFFF));
        item.miso       = 1'($urandom_range(0, 1));
        send_tick(item);
    endtask

    task automatic test_reads();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_request(MODE_READ, 1'b1, 16'h0000, 16'h0000, 16'h00A5);
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        // word address doubling wraps past the top
        run_request(MODE_READ, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_request(MODE_READ, 1'b0, 16'h8000, 16'h1234, 16'h0000);
        run_request(MODE_READ, 1'b1, 16'hFFFF, 16'hFFFF, 16'h005A);
    endtask

    task automatic test_writes();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b0;
        run_request(MODE_WRITE, 1'b1, 16'h1357, 16'h00C3, 16'h77C3);
        // byte read is zero-extended, so a non-zero high byte never matches
        run_request(MODE_WRITE, 1'b1, 16'hFFFF, 16'hFF3C, 16'h003C);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b1;
        run_request(MODE_WRITE, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF);
        run_request(MODE_WRITE, 1'b0, 16'h7FFF, 16'h1234, 16'h0000);
        run_request(MODE_WRITE, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);
    endtask

    task automatic test_idle_modes();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_idle_tick(MODE_UNUSED);
        send_idle_tick(MODE_NONE);
        send_idle_tick(MODE_UNUSED);
        send_idle_tick(MODE_NONE);
    endtask

    task automatic test_random();
        logic [1:0]  req;
        logic        bmode;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [15:0] stored;
        while (ticks_sent < TICK_BUDGET) begin
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                send_idle_tick($urandom_range(0, 1) ? MODE_NONE : MODE_UNUSED);
            end
            req   = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
            bmode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       addr = 16'h0000;
                1:       addr = 16'hFFFF;
                default: addr = 16'($urandom_range(0, 16'hFFFF));
            endcase
            wdata = 16'($urandom_range(0, 16'hFFFF));
            if (bmode && $urandom_range(0, 1)) begin
                wdata[15:8] = 8'h00;
            end
            stored = (req == MODE_WRITE && $urandom_range(0, 4) < 2)
                     ? wdata : 16'($urandom_range(0, 16'hFFFF));
            run_request(req, bmode, addr, wdata, stored);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= idle_len(receiver_stalls);
        end
    end

    always @(posedge aclk) begin : check_results
        spifas_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_bus_states.size() == 0) begin
                flag_error("result transaction with nothing pending");
            end else begin
                want = due_bus_states.pop_front();
                compare_field("chip_select", 16'(m_data.chip_select),
                              16'(want.chip_select));
                compare_field("sclk", 16'(m_data.sclk), 16'(want.sclk));
                compare_field("mosi", 16'(m_data.mosi), 16'(want.mosi));
                compare_field("busy_res", 16'(m_data.busy_res), 16'(want.busy_res));
                compare_field("done_res", 16'(m_data.done_res), 16'(want.done_res));
                compare_field("read_data", m_data.read_data, want.read_data);
                compare_field("write_skipped", 16'(m_data.write_skipped),
                              16'(want.write_skipped));
            end
        end
    end

    initial begin
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reads();
        test_writes();
        test_idle_modes();
        test_random();
        s_valid <= 1'b0;
        waited = 0;
        while (due_bus_states.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (due_bus_states.size() != 0) begin
            flag_error($sformatf("%0d result transactions never arrived",
                                 due_bus_states.size()));
        end
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("spi_fram_access_sequencer: match");
        end else begin
            $display("spi_fram_access_sequencer: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("spi_fram_access_sequencer: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/spifas_pkg.sv
rtl/core/spifas_frame_byte.sv
rtl/core/spi_fram_access_sequencer.sv
rtl/core/spifas_checker.sv
test/spi_fram_access_sequencer_test.sv
